@@ sv/assert_macros.svh @@
// Assertion helpers, sampled on the rising clock edge and quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

@@ sv/nfd_pkg.sv @@
package nfd_pkg;

   localparam int LIST_DEPTH  = 32;
   localparam int MAX_FRAGS   = 64;
   localparam int HDR_LEN     = 4;

   // index store address width
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_RD,
      ST_LOAD
   } state_type;

endpackage

@@ sv/nfd_ram.sv @@
module nfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ sv/nack_frame_decoder_core.sv @@
// NACK frame decoder. Frame bytes are taken one per clock on req_ while the block is
// receiving and the output register is free or draining; frame_end (req_tlast) closes
// the frame. A rejected frame puts one result with ok = 0 into the output register at
// the closing byte, and byte taking goes on without a gap unless the output stalls. A
// valid frame stops byte taking and replays the buffered indices from the index RAM,
// each by a RAM read held while the output register is busy, then an output load.
// Index RAM has no clearing pass: only entries written by the current frame are read.
`include "assert_macros.svh"

module nack_frame_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nfd_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] message_type, [15:8] msg_id, [23:16] total_fragments, [29:24] missing_total,
   // [37:30] missing_index, [39:38] zero
   output logic [nfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,   // ok
   output logic                              rsp_tlast    // run_last
);

   nfd_pkg::state_type state_ff, state_in;

   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] hdr_type_ff, hdr_type_in;
   logic [7:0] hdr_id_ff, hdr_id_in;
   logic [7:0] hdr_total_ff, hdr_total_in;
   logic [7:0] hdr_count_ff, hdr_count_in;
   logic       bad_ff, bad_in;
   logic [nfd_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [7:0]  rsp_id_ff, rsp_id_in;
   logic [7:0]  rsp_total_ff, rsp_total_in;
   logic [5:0]  rsp_count_ff, rsp_count_in;
   logic [7:0]  rsp_index_ff, rsp_index_in;

   logic       accept;
   logic       out_free;
   logic [8:0] slot;
   logic       wr_en;
   logic       rd_en;
   logic [7:0] ram_rd_data;
   logic       frame_ok;
   logic       idx_last;

   nfd_ram #(
      .Width (8),
      .Depth (nfd_pkg::LIST_DEPTH)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot[nfd_pkg::IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == nfd_pkg::ST_RECV) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign slot       = {1'b0, byte_count_ff} - 9'(nfd_pkg::HDR_LEN);
   assign wr_en      = accept && (byte_count_ff >= 8'(nfd_pkg::HDR_LEN))
                       && (slot < 9'(nfd_pkg::LIST_DEPTH));
   assign rd_en      = (state_ff == nfd_pkg::ST_RD) && out_free;
   assign idx_last   = (8'(rd_idx_ff) + 8'd1) == hdr_count_ff;

   always_comb begin
      byte_count_in = byte_count_ff;
      hdr_type_in   = hdr_type_ff;
      hdr_id_in     = hdr_id_ff;
      hdr_total_in  = hdr_total_ff;
      hdr_count_in  = hdr_count_ff;
      bad_in        = bad_ff;
      frame_ok      = 1'b0;

      if (accept) begin
         unique case (byte_count_ff)
            8'd0:    hdr_type_in  = req_tdata;
            8'd1:    hdr_id_in    = req_tdata;
            8'd2:    hdr_total_in = req_tdata;
            8'd3:    hdr_count_in = req_tdata;
            default: begin
               if (req_tdata >= hdr_total_ff) begin
                  bad_in = 1'b1;
               end
            end
         endcase
         if (byte_count_ff != 8'hFF) begin
            byte_count_in = byte_count_ff + 8'd1;
         end
         frame_ok = (byte_count_in >= 8'(nfd_pkg::HDR_LEN))
                    && (hdr_count_in != 8'd0)
                    && ({1'b0, hdr_count_in} <= 9'(nfd_pkg::LIST_DEPTH))
                    && (hdr_total_in != 8'd0)
                    && ({1'b0, hdr_total_in} <= 9'(nfd_pkg::MAX_FRAGS))
                    && ({1'b0, byte_count_in}
                        == 9'(nfd_pkg::HDR_LEN) + {1'b0, hdr_count_in})
                    && !bad_in;
         if (req_tlast) begin
            byte_count_in = 8'd0;
            bad_in        = 1'b0;
         end
      end
   end

   // emit sequencer and output register
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_index_in = rsp_index_ff;

      unique case (state_ff)
         nfd_pkg::ST_RECV: begin
            if (accept && req_tlast) begin
               if (frame_ok) begin
                  rd_idx_in = '0;
                  state_in  = nfd_pkg::ST_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_type_in  = 8'd0;
                  rsp_id_in    = 8'd0;
                  rsp_total_in = 8'd0;
                  rsp_count_in = 6'd0;
                  rsp_index_in = 8'd0;
               end
            end
         end
         nfd_pkg::ST_RD: begin
            if (out_free) begin
               state_in = nfd_pkg::ST_LOAD;
            end
         end
         nfd_pkg::ST_LOAD: begin
            // register was free or drained when the read issued
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_last_in  = idx_last;
            rsp_type_in  = hdr_type_ff;
            rsp_id_in    = hdr_id_ff;
            rsp_total_in = hdr_total_ff;
            rsp_count_in = hdr_count_ff[5:0];
            rsp_index_in = ram_rd_data;
            if (idx_last) begin
               state_in = nfd_pkg::ST_RECV;
            end else begin
               rd_idx_in = rd_idx_ff + nfd_pkg::IDX_W'(1);
               state_in  = nfd_pkg::ST_RD;
            end
         end
         default: state_in = nfd_pkg::ST_RECV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nfd_pkg::ST_RECV;
         byte_count_ff <= '0;
         hdr_type_ff   <= '0;
         hdr_id_ff     <= '0;
         hdr_total_ff  <= '0;
         hdr_count_ff  <= '0;
         bad_ff        <= 1'b0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         hdr_type_ff   <= hdr_type_in;
         hdr_id_ff     <= hdr_id_in;
         hdr_total_ff  <= hdr_total_in;
         hdr_count_ff  <= hdr_count_in;
         bad_ff        <= bad_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_count_ff, rsp_total_ff,
                        rsp_id_ff, rsp_type_ff};

   `ASSERT_CLK(a_load_into_free, (state_ff == nfd_pkg::ST_LOAD) |-> !rsp_valid_ff, "output register busy at RAM data load")
   `ASSERT_CLK(a_idx_in_range, (state_ff != nfd_pkg::ST_RECV) |-> (8'(rd_idx_ff) < hdr_count_ff), "replay index past missing count")
   `ASSERT_CLK(a_count_clear_emit, (state_ff != nfd_pkg::ST_RECV) |-> (byte_count_ff == 8'd0 && !bad_ff), "frame state not cleared during replay")
   `ASSERT_NEXT(a_last_ends_run, (state_ff == nfd_pkg::ST_LOAD && idx_last), (state_ff == nfd_pkg::ST_RECV && rsp_last_ff), "final index did not close the run")

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef bit [7:0] frame_type[$];

   typedef struct {
      bit       ok;
      bit [7:0] message_type;
      bit [7:0] msg_id;
      bit [7:0] total_fragments;
      bit [5:0] missing_total;
      bit [7:0] missing_index;
      bit       run_last;
   } nack_result_type;

   typedef enum int {
      BREAK_JUNK,
      BREAK_INDEX,
      BREAK_EXTRA,
      BREAK_TRUNC,
      BREAK_HEADER
   } break_kind_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [nfd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [nfd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;

   nack_frame_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as seen from the outside
   bit [7:0] frame_len;
   bit [7:0] hdr_type_q, hdr_id_q, hdr_total_q, hdr_count_q;
   bit       index_out_of_range;
   bit [7:0] missing_buf [nfd_pkg::LIST_DEPTH];

   nack_result_type pending_results[$];
   int unsigned     errors;
   int unsigned     items_sent;
   bit              req_steady;
   bit              rsp_steady;
   int unsigned     rsp_hold;
   int unsigned     rsp_gap;

   function automatic void decode_byte(bit [7:0] b, bit fin);
      int              slot;
      bit              good;
      nack_result_type r;
      case (frame_len)
         8'd0: hdr_type_q  = b;
         8'd1: hdr_id_q    = b;
         8'd2: hdr_total_q = b;
         8'd3: hdr_count_q = b;
         default: begin
            slot = int'(frame_len) - nfd_pkg::HDR_LEN;
            if (slot < nfd_pkg::LIST_DEPTH) missing_buf[slot] = b;
            if (b >= hdr_total_q) index_out_of_range = 1'b1;
         end
      endcase
      if (frame_len != 8'd255) frame_len++;
      if (!fin) return;

      good = frame_len >= nfd_pkg::HDR_LEN
          && hdr_count_q != 0 && hdr_count_q <= nfd_pkg::LIST_DEPTH
          && hdr_total_q != 0 && hdr_total_q <= nfd_pkg::MAX_FRAGS
          && int'(frame_len) == nfd_pkg::HDR_LEN + int'(hdr_count_q)
          && !index_out_of_range;

      if (!good) begin
         r = '{ok: 1'b0, message_type: 8'd0, msg_id: 8'd0, total_fragments: 8'd0,
               missing_total: 6'd0, missing_index: 8'd0, run_last: 1'b1};
         pending_results.push_back(r);
      end else begin
         for (int i = 0; i < hdr_count_q && i < nfd_pkg::LIST_DEPTH; i++) begin
            r.ok              = 1'b1;
            r.message_type    = hdr_type_q;
            r.msg_id          = hdr_id_q;
            r.total_fragments = hdr_total_q;
            r.missing_total   = hdr_count_q[5:0];
            r.missing_index   = missing_buf[i];
            r.run_last        = (i + 1 == hdr_count_q);
            pending_results.push_back(r);
         end
      end
      frame_len          = 8'd0;
      index_out_of_range = 1'b0;
   endfunction

   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      nack_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: tdata=%h ok=%b last=%b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            e = pending_results.pop_front();
            check_field("ok", e.ok, rsp_tuser);
            check_field("message_type", e.message_type, rsp_tdata[7:0]);
            check_field("msg_id", e.msg_id, rsp_tdata[15:8]);
            check_field("total_fragments", e.total_fragments, rsp_tdata[23:16]);
            check_field("missing_total", e.missing_total, rsp_tdata[29:24]);
            check_field("missing_index", e.missing_index, rsp_tdata[37:30]);
            check_field("run_last", e.run_last, rsp_tlast);
         end
      end
   end

   // result side backpressure: a fresh stall length after every transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (!rsp_tready) begin
         if (rsp_hold > 1) begin
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= 0;
         end
      end else if (rsp_tvalid) begin
         rsp_gap = rsp_steady ? 0 : $urandom_range(0, 6);
         if (rsp_gap != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_gap;
         end
      end
   end

   task automatic send_byte(bit [7:0] b, bit fin);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      decode_byte(b, fin);
   endtask

   task automatic send_frame(frame_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   // always moves past the current edge, so the next drive lands in a later step
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic frame_type make_frame(int total, int count);
      frame_type f;
      f.push_back(8'($urandom_range(0, 255)));
      f.push_back(8'($urandom_range(0, 255)));
      f.push_back(total[7:0]);
      f.push_back(count[7:0]);
      for (int i = 0; i < count; i++) f.push_back(8'($urandom_range(0, total - 1)));
      return f;
   endfunction

   task automatic test_min_frame();
      frame_type f;
      f = {8'hFF, 8'hFF, 8'd1, 8'd1, 8'd0};
      send_frame(f);
      f = {8'h00, 8'h00, 8'd255, 8'd1, 8'd0};   // total too big
      send_frame(f);
   endtask

   task automatic test_max_frame();
      frame_type f;
      f = make_frame(nfd_pkg::MAX_FRAGS, nfd_pkg::LIST_DEPTH);
      f[0] = 8'h00;
      f[1] = 8'hA5;
      f[4] = 8'(nfd_pkg::MAX_FRAGS - 1);
      f[5] = 8'd0;
      send_frame(f);
   endtask

   // stale header registers must not leak into the rejection
   task automatic test_short_frames();
      frame_type f;
      f = {8'h5A};
      send_frame(f);
      f = {8'h11, 8'h22};
      send_frame(f);
      f = {8'h11, 8'h22, 8'd10};
      send_frame(f);
   endtask

   task automatic test_bad_header();
      frame_type f;
      f = {8'h01, 8'h02, 8'd8, 8'd0};                                // no missing entries
      send_frame(f);
      f = make_frame(nfd_pkg::MAX_FRAGS, nfd_pkg::LIST_DEPTH + 1);   // list over capacity
      send_frame(f);
      f = {8'h03, 8'h04, 8'd0, 8'd1, 8'd0};                          // zero total
      send_frame(f);
      f = {8'h05, 8'h06, 8'(nfd_pkg::MAX_FRAGS + 1), 8'd1, 8'd64};
      send_frame(f);
   endtask

   task automatic test_length_mismatch();
      frame_type f;
      f = {8'h07, 8'h08, 8'd20, 8'd3, 8'd1, 8'd2};
      send_frame(f);
      f = {8'h09, 8'h0A, 8'd20, 8'd2, 8'd1, 8'd2, 8'd3};
      send_frame(f);
   endtask

   task automatic test_bad_index();
      frame_type f;
      f = {8'h0B, 8'h0C, 8'd5, 8'd2, 8'd4, 8'd5};   // index equals total
      send_frame(f);
      f = {8'h0D, 8'h0E, 8'd64, 8'd1, 8'd255};
      send_frame(f);
   endtask

   // byte counter saturation: 261 bytes with in-range indices; a wrapping counter
   // would land on the legal length 5 and accept the frame
   task automatic test_long_frame();
      frame_type f;
      f = make_frame(nfd_pkg::MAX_FRAGS, 1);
      for (int i = 0; i < 256; i++) begin
         f.push_back(8'($urandom_range(0, nfd_pkg::MAX_FRAGS - 1)));
      end
      req_steady = 1'b1;
      send_frame(f);
      req_steady = 1'b0;
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 3; i++) begin
         send_frame(make_frame($urandom_range(8, nfd_pkg::MAX_FRAGS), $urandom_range(1, 6)));
         wait_drained();
      end
      // back to back: next frame starts while the replay is still busy
      send_frame(make_frame(nfd_pkg::MAX_FRAGS, 8));
      send_frame(make_frame($urandom_range(1, nfd_pkg::MAX_FRAGS), 1));
   endtask

   task automatic test_random();
      int             total;
      int             count;
      int             k;
      frame_type      f;
      break_kind_type kind;
      while (items_sent < 470) begin
         req_steady = ($urandom_range(0, 7) == 0);
         rsp_steady = ($urandom_range(0, 7) == 0);
         total = $urandom_range(1, nfd_pkg::MAX_FRAGS);
         count = ($urandom_range(0, 15) == 0) ? $urandom_range(1, nfd_pkg::LIST_DEPTH)
                                               : $urandom_range(1, 8);
         f = make_frame(total, count);
         if ($urandom_range(0, 4) == 0) begin
            kind = break_kind_type'($urandom_range(0, 4));
            case (kind)
               BREAK_JUNK: begin
                  f = {};
                  repeat ($urandom_range(1, 10)) f.push_back(8'($urandom_range(0, 255)));
               end
               BREAK_INDEX: begin
                  k = $urandom_range(0, count - 1);
                  f[4 + k] = 8'($urandom_range(total, 255));
               end
               BREAK_EXTRA: f.push_back(8'($urandom_range(0, total - 1)));
               BREAK_TRUNC: void'(f.pop_back());
               BREAK_HEADER: begin
                  if ($urandom_range(0, 1))
                     f[2] = $urandom_range(0, 1) ? 8'd0
                            : 8'($urandom_range(nfd_pkg::MAX_FRAGS + 1, 255));
                  else
                     f[3] = $urandom_range(0, 1) ? 8'd0
                            : 8'($urandom_range(nfd_pkg::LIST_DEPTH + 1, 255));
               end
               default: ;
            endcase
         end
         send_frame(f);
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      errors             = 0;
      items_sent         = 0;
      req_steady         = 1'b0;
      rsp_steady         = 1'b0;
      frame_len          = 8'd0;
      hdr_type_q         = 8'd0;
      hdr_id_q           = 8'd0;
      hdr_total_q        = 8'd0;
      hdr_count_q        = 8'd0;
      index_out_of_range = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_min_frame();
      test_max_frame();
      test_short_frames();
      test_bad_header();
      test_length_mismatch();
      test_bad_index();
      test_long_frame();
      test_drain_pause();
      test_random();

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
